// File: sv/bki_pkg.sv
// Shared types, widths and field layout for the Bezier keyframe interpolator.
// No dependencies; used by bki_divider and bezier_keyframe_interpolator.
package bki_pkg;

    localparam int T_FRAC_BITS = 16;

    localparam int POS_W  = 31;
    localparam int VAL_W  = 32;
    localparam int CP_W   = VAL_W + 1;
    localparam int DIFF_W = CP_W + 1;
    localparam int T_W    = T_FRAC_BITS + 1;
    localparam int PROD_W = DIFF_W + T_W + 1;

    localparam logic [T_W-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};
    localparam logic signed [PROD_W-1:0] T_HALF = PROD_W'(1) << (T_FRAC_BITS - 1);

    // input tdata layout
    localparam int IN_TDATA_W  = 256;
    localparam int IN_TUSER_W  = 4;
    localparam int FRAME_LSB   = 0;
    localparam int BPOS_LSB    = FRAME_LSB + POS_W;
    localparam int APOS_LSB    = BPOS_LSB + POS_W;
    localparam int BVAL_LSB    = APOS_LSB + POS_W;
    localparam int BCTRL_LSB   = BVAL_LSB + VAL_W;
    localparam int AVAL_LSB    = BCTRL_LSB + VAL_W;
    localparam int ACTRL_LSB   = AVAL_LSB + VAL_W;
    localparam int DVAL_LSB    = ACTRL_LSB + VAL_W;

    // input tuser layout
    localparam int U_ACTION    = 0;
    localparam int U_REVERSE   = 1;
    localparam int U_HAS_BEF   = 2;
    localparam int U_HAS_AFT   = 3;

    localparam int OUT_TDATA_W = 32;
    localparam int OUT_TUSER_W = 2;

    typedef enum logic [1:0] {
        SRC_DEFAULT = 2'd0,
        SRC_BEFORE  = 2'd1,
        SRC_AFTER   = 2'd2,
        SRC_INTERP  = 2'd3
    } src_t;

    // carried alongside the divider
    typedef struct packed {
        logic                    linear;
        src_t                    src;
        logic                    force_one;
        logic signed [VAL_W-1:0] hold;
        logic signed [VAL_W-1:0] bv;
        logic signed [VAL_W-1:0] av;
        logic signed [CP_W-1:0]  c1;
        logic signed [CP_W-1:0]  c2;
    } side_t;

endpackage

// File: sv/bki_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with per-stage valid.
// Depends on bki_pkg (widths, side_t).
module bki_divider (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bki_pkg::POS_W-1:0]     in_dividend,
    input  logic [bki_pkg::POS_W-1:0]     in_divisor,
    input  bki_pkg::side_t                in_side,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bki_pkg::T_FRAC_BITS-1:0] out_quotient,
    output bki_pkg::side_t                out_side
);

    localparam int N  = bki_pkg::T_FRAC_BITS;
    localparam int PW = bki_pkg::POS_W;

    logic                 valid_reg [N];
    logic [PW-1:0]        rem_reg   [N];
    logic [PW-1:0]        div_reg   [N];
    logic [N-1:0]         quo_reg   [N];
    bki_pkg::side_t       side_reg  [N];

    logic                 enable    [N];
    logic                 src_valid [N];
    logic [PW-1:0]        src_rem   [N];
    logic [PW-1:0]        src_div   [N];
    logic [N-1:0]         src_quo   [N];
    bki_pkg::side_t       src_side  [N];
    logic [PW:0]          shl       [N];
    logic                 ge        [N];
    logic [PW-1:0]        rem_next  [N];
    logic [N-1:0]         quo_next  [N];

    always_comb begin
        enable[N-1] = !valid_reg[N-1] || out_ready;
        for (int k = N - 2; k >= 0; k--) begin
            enable[k] = !valid_reg[k] || enable[k+1];
        end
    end

    always_comb begin
        src_valid[0] = in_valid;
        src_rem[0]   = in_dividend;
        src_div[0]   = in_divisor;
        src_quo[0]   = '0;
        src_side[0]  = in_side;
        for (int k = 1; k < N; k++) begin
            src_valid[k] = valid_reg[k-1];
            src_rem[k]   = rem_reg[k-1];
            src_div[k]   = div_reg[k-1];
            src_quo[k]   = quo_reg[k-1];
            src_side[k]  = side_reg[k-1];
        end
        for (int k = 0; k < N; k++) begin
            shl[k]      = {src_rem[k], 1'b0};
            ge[k]       = shl[k] >= {1'b0, src_div[k]};
            rem_next[k] = ge[k] ? PW'(shl[k] - {1'b0, src_div[k]}) : shl[k][PW-1:0];
            quo_next[k] = {src_quo[k][N-2:0], ge[k]};
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < N; k++) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (enable[k]) begin
                valid_reg[k] <= src_valid[k];
            end
            if (enable[k]) begin
                rem_reg[k]  <= rem_next[k];
                div_reg[k]  <= src_div[k];
                quo_reg[k]  <= quo_next[k];
                side_reg[k] <= src_side[k];
            end
        end
    end

    assign in_ready     = enable[0];
    assign out_valid    = valid_reg[N-1];
    assign out_quotient = quo_reg[N-1];
    assign out_side     = side_reg[N-1];

    a_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid |-> (in_dividend < in_divisor) || (in_dividend == '0))
        else $error("divider fed a dividend not below its divisor");

    a_rem_below: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[N-1] |-> (rem_reg[N-1] < div_reg[N-1]) || (div_reg[N-1] == '0))
        else $error("final remainder not below divisor");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[N-1] && !out_ready |=> valid_reg[N-1] && $stable(quo_reg[N-1]))
        else $error("stalled quotient lost or changed");

endmodule

// File: sv/bezier_keyframe_interpolator.sv
// Top level: cubic Bezier / linear keyframe interpolation of one curve axis.
// Depends on bki_pkg and bki_divider.
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  tdata: keyframes, values, frame; tuser: flags
//  m_       out  m_tvalid/m_tready  tdata: value; tuser: source
//
// One transaction per cycle sustained while m_tready stays high. Stages: input
// stage, one divider stage per bit of t, then three lerp levels of multiply and
// add stages, and an output register. Every stage has its own valid bit and loads
// when empty or when the stage after it moves, so bubbles fill during a stall.
// aresetn clears valid bits only.
module bezier_keyframe_interpolator (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // frame, before_pos, after_pos, before_value, before_ctrl, after_value,
    // after_ctrl, default_value, zero pad
    input  logic [bki_pkg::IN_TDATA_W-1:0]      s_tdata,
    // action, reverse, has_before, has_after
    input  logic [bki_pkg::IN_TUSER_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // value
    output logic [bki_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // source
    output logic [bki_pkg::OUT_TUSER_W-1:0]     m_tuser
);

    localparam int VW = bki_pkg::VAL_W;
    localparam int PW = bki_pkg::POS_W;
    localparam int CW = bki_pkg::CP_W;
    localparam int DW = bki_pkg::DIFF_W;
    localparam int TW = bki_pkg::T_W;
    localparam int RW = bki_pkg::PROD_W;

    function automatic logic signed [RW-1:0] mul_diff(
        input logic signed [CW-1:0] a,
        input logic signed [CW-1:0] b,
        input logic [TW-1:0]        t
    );
        logic signed [DW-1:0] diff;
        logic signed [TW:0]   tt;
        diff = DW'(b) - DW'(a);
        tt   = {1'b0, t};
        return RW'(diff) * RW'(tt);
    endfunction

    function automatic logic signed [CW-1:0] lerp_add(
        input logic signed [CW-1:0] a,
        input logic signed [RW-1:0] p
    );
        logic signed [RW-1:0] sum;
        sum = RW'(a) + ((p + bki_pkg::T_HALF) >>> bki_pkg::T_FRAC_BITS);
        return sum[CW-1:0];
    endfunction

    function automatic logic signed [VW-1:0] sat(input logic signed [CW-1:0] v);
        if (v[CW-1] != v[CW-2]) begin
            return v[CW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
        end
        return v[VW-1:0];
    endfunction

    // ---------------- input stage ----------------
    logic                 v1_reg;
    logic signed [VW-1:0] d1_reg, e1_reg, s1_reg;
    logic signed [VW-1:0] bv1_reg, av1_reg, dv1_reg;
    logic signed [CW-1:0] c11_reg, c21_reg;
    logic                 hb1_reg, ha1_reg, lin1_reg;

    logic signed [VW-1:0] f_val;
    logic signed [VW-1:0] bv_in, av_in, bc_in, ac_in;
    logic                 en1;

    always_comb begin
        f_val = VW'({1'b0, s_tdata[bki_pkg::FRAME_LSB +: PW]})
              - VW'(s_tuser[bki_pkg::U_REVERSE]);
        bv_in = s_tdata[bki_pkg::BVAL_LSB +: VW];
        bc_in = s_tdata[bki_pkg::BCTRL_LSB +: VW];
        av_in = s_tdata[bki_pkg::AVAL_LSB +: VW];
        ac_in = s_tdata[bki_pkg::ACTRL_LSB +: VW];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en1) begin
            v1_reg <= s_tvalid;
        end
        if (en1) begin
            d1_reg   <= f_val - VW'({1'b0, s_tdata[bki_pkg::BPOS_LSB +: PW]});
            e1_reg   <= f_val - VW'({1'b0, s_tdata[bki_pkg::APOS_LSB +: PW]});
            s1_reg   <= VW'({1'b0, s_tdata[bki_pkg::APOS_LSB +: PW]})
                      - VW'({1'b0, s_tdata[bki_pkg::BPOS_LSB +: PW]});
            bv1_reg  <= bv_in;
            av1_reg  <= av_in;
            dv1_reg  <= s_tdata[bki_pkg::DVAL_LSB +: VW];
            c11_reg  <= CW'(bv_in) + CW'(bc_in);
            c21_reg  <= CW'(av_in) + CW'(ac_in);
            hb1_reg  <= s_tuser[bki_pkg::U_HAS_BEF];
            ha1_reg  <= s_tuser[bki_pkg::U_HAS_AFT];
            lin1_reg <= s_tuser[bki_pkg::U_ACTION];
        end
    end

    // ---------------- case decision, divider feed ----------------
    bki_pkg::side_t       side_in;
    logic [PW-1:0]        dividend;
    logic                 d_pos;

    always_comb begin
        side_in.linear = lin1_reg;
        side_in.bv     = bv1_reg;
        side_in.av     = av1_reg;
        side_in.c1     = c11_reg;
        side_in.c2     = c21_reg;
        if (!hb1_reg && !ha1_reg) begin
            side_in.src  = bki_pkg::SRC_DEFAULT;
            side_in.hold = dv1_reg;
        end else if (hb1_reg && (!ha1_reg || d1_reg == '0)) begin
            side_in.src  = bki_pkg::SRC_BEFORE;
            side_in.hold = bv1_reg;
        end else if (ha1_reg && (!hb1_reg || e1_reg == '0)) begin
            side_in.src  = bki_pkg::SRC_AFTER;
            side_in.hold = av1_reg;
        end else if (s1_reg <= 0) begin
            side_in.src  = bki_pkg::SRC_BEFORE;
            side_in.hold = bv1_reg;
        end else begin
            side_in.src  = bki_pkg::SRC_INTERP;
            side_in.hold = bv1_reg;
        end
        d_pos             = d1_reg > 0;
        side_in.force_one = d_pos && (d1_reg >= s1_reg);
        dividend          = (d_pos && (d1_reg < s1_reg)) ? d1_reg[PW-1:0] : '0;
    end

    logic                               div_in_ready;
    logic                               div_out_valid;
    logic [bki_pkg::T_FRAC_BITS-1:0]    div_quotient;
    bki_pkg::side_t                     div_side;
    logic                               en_l1m;

    assign en1 = !v1_reg || div_in_ready;

    bki_divider u_div (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (v1_reg),
        .in_ready     (div_in_ready),
        .in_dividend  (dividend),
        .in_divisor   (s1_reg[PW-1:0]),
        .in_side      (side_in),
        .out_valid    (div_out_valid),
        .out_ready    (en_l1m),
        .out_quotient (div_quotient),
        .out_side     (div_side)
    );

    // ---------------- lerp levels ----------------
    logic                 v_l1m_reg, v_l1a_reg, v_l2m_reg, v_l2a_reg, v_l3m_reg, v_l3a_reg;
    logic                 v_out_reg;
    logic [TW-1:0]        t_l1m_reg, t_l1a_reg, t_l2m_reg, t_l2a_reg;
    bki_pkg::side_t       sd_l1m_reg, sd_l1a_reg, sd_l2m_reg, sd_l2a_reg, sd_l3m_reg, sd_l3a_reg;
    logic signed [RW-1:0] p_l1m_reg [3];
    logic signed [CW-1:0] q_l1a_reg [3];
    logic signed [RW-1:0] p_l2m_reg [2];
    logic signed [CW-1:0] a_l2m_reg [2];
    logic signed [CW-1:0] r_l2a_reg [2];
    logic signed [RW-1:0] p_l3m_reg;
    logic signed [CW-1:0] a_l3m_reg;
    logic signed [CW-1:0] res_l3a_reg;
    logic signed [VW-1:0] val_out_reg;
    bki_pkg::src_t        src_out_reg;

    logic                 en_l1a, en_l2m, en_l2a, en_l3m, en_l3a, en_out;
    logic [TW-1:0]        t_sel;
    logic signed [CW-1:0] a3_sel, b3_sel;

    always_comb begin
        en_out = !v_out_reg || m_tready;
        en_l3a = !v_l3a_reg || en_out;
        en_l3m = !v_l3m_reg || en_l3a;
        en_l2a = !v_l2a_reg || en_l3m;
        en_l2m = !v_l2m_reg || en_l2a;
        en_l1a = !v_l1a_reg || en_l2m;
        en_l1m = !v_l1m_reg || en_l1a;
        t_sel  = div_side.force_one ? bki_pkg::T_ONE : {1'b0, div_quotient};
        a3_sel = sd_l2a_reg.linear ? CW'(sd_l2a_reg.bv) : r_l2a_reg[0];
        b3_sel = sd_l2a_reg.linear ? CW'(sd_l2a_reg.av) : r_l2a_reg[1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_l1m_reg <= 1'b0;
            v_l1a_reg <= 1'b0;
            v_l2m_reg <= 1'b0;
            v_l2a_reg <= 1'b0;
            v_l3m_reg <= 1'b0;
            v_l3a_reg <= 1'b0;
            v_out_reg <= 1'b0;
        end else begin
            if (en_l1m) v_l1m_reg <= div_out_valid;
            if (en_l1a) v_l1a_reg <= v_l1m_reg;
            if (en_l2m) v_l2m_reg <= v_l1a_reg;
            if (en_l2a) v_l2a_reg <= v_l2m_reg;
            if (en_l3m) v_l3m_reg <= v_l2a_reg;
            if (en_l3a) v_l3a_reg <= v_l3m_reg;
            if (en_out) v_out_reg <= v_l3a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_l1m) begin
            t_l1m_reg    <= t_sel;
            sd_l1m_reg   <= div_side;
            p_l1m_reg[0] <= mul_diff(CW'(div_side.bv), div_side.c1, t_sel);
            p_l1m_reg[1] <= mul_diff(div_side.c1, div_side.c2, t_sel);
            p_l1m_reg[2] <= mul_diff(div_side.c2, CW'(div_side.av), t_sel);
        end
        if (en_l1a) begin
            t_l1a_reg    <= t_l1m_reg;
            sd_l1a_reg   <= sd_l1m_reg;
            q_l1a_reg[0] <= lerp_add(CW'(sd_l1m_reg.bv), p_l1m_reg[0]);
            q_l1a_reg[1] <= lerp_add(sd_l1m_reg.c1, p_l1m_reg[1]);
            q_l1a_reg[2] <= lerp_add(sd_l1m_reg.c2, p_l1m_reg[2]);
        end
        if (en_l2m) begin
            t_l2m_reg    <= t_l1a_reg;
            sd_l2m_reg   <= sd_l1a_reg;
            a_l2m_reg[0] <= q_l1a_reg[0];
            a_l2m_reg[1] <= q_l1a_reg[1];
            p_l2m_reg[0] <= mul_diff(q_l1a_reg[0], q_l1a_reg[1], t_l1a_reg);
            p_l2m_reg[1] <= mul_diff(q_l1a_reg[1], q_l1a_reg[2], t_l1a_reg);
        end
        if (en_l2a) begin
            t_l2a_reg    <= t_l2m_reg;
            sd_l2a_reg   <= sd_l2m_reg;
            r_l2a_reg[0] <= lerp_add(a_l2m_reg[0], p_l2m_reg[0]);
            r_l2a_reg[1] <= lerp_add(a_l2m_reg[1], p_l2m_reg[1]);
        end
        if (en_l3m) begin
            sd_l3m_reg   <= sd_l2a_reg;
            a_l3m_reg    <= a3_sel;
            p_l3m_reg    <= mul_diff(a3_sel, b3_sel, t_l2a_reg);
        end
        if (en_l3a) begin
            sd_l3a_reg   <= sd_l3m_reg;
            res_l3a_reg  <= lerp_add(a_l3m_reg, p_l3m_reg);
        end
        if (en_out) begin
            src_out_reg  <= sd_l3a_reg.src;
            val_out_reg  <= (sd_l3a_reg.src == bki_pkg::SRC_INTERP) ? sat(res_l3a_reg)
                                                                    : sd_l3a_reg.hold;
        end
    end

    assign s_tready = en1;
    assign m_tvalid = v_out_reg;
    assign m_tdata  = val_out_reg;
    assign m_tuser  = src_out_reg;

    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> v1_reg)
        else $error("accepted transaction did not enter the input stage");

    a_t_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v_l1m_reg && sd_l1m_reg.src == bki_pkg::SRC_INTERP |-> t_l1m_reg <= bki_pkg::T_ONE)
        else $error("interpolation parameter above one");

    a_t_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        v_l1a_reg && t_l1a_reg == '0 |-> q_l1a_reg[0] == CW'(sd_l1a_reg.bv))
        else $error("lerp at t of zero moved off its start point");

endmodule
